@@ rtl/core/esrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esrf_pkg
// Shared types and constants of the soft ellipsoid restoring force block.
// ----------------------------------------------------------------------------
package esrf_pkg;

    typedef enum logic [2:0] {
        CFG_TWO_ELLIPSOIDS    = 3'd0,
        CFG_THREE_DIMENSIONAL = 3'd1,
        CFG_INV_A_SQ          = 3'd2,
        CFG_INV_B_SQ          = 3'd3,
        CFG_INV_BV_SQ         = 3'd4,
        CFG_INV_C_SQ          = 3'd5,
        CFG_STIFFNESS         = 3'd6
    } cfg_index_t;

    localparam logic        RST_TWO_ELLIPSOIDS    = 1'b0;
    localparam logic        RST_THREE_DIMENSIONAL = 1'b1;
    localparam logic [31:0] RST_INV_SQ            = 32'h0100_0000;
    localparam logic [31:0] RST_STIFFNESS         = 32'h0001_0000;

    localparam logic [63:0] Q24_ONE  = 64'h0000_0000_0100_0000;
    localparam logic [48:0] TERM_CAP = 49'h1_0000_0000_0000;

    typedef struct packed {
        logic        two_ellipsoids;
        logic        three_dimensional;
        logic [31:0] inv_a_sq;
        logic [31:0] inv_b_sq;
        logic [31:0] inv_bv_sq;
        logic [31:0] inv_c_sq;
        logic [31:0] stiffness;
    } cfg_t;

    // stiffness * |E| and the sign of E, shared by the three axes
    typedef struct packed {
        logic [95:0] es;
        logic        eneg;
    } energy_t;

endpackage

@@ rtl/core/esrf_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esrf_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module esrf_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output esrf_pkg::cfg_t      cfg
);

    esrf_pkg::cfg_t cfg_reg;
    esrf_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                esrf_pkg::CFG_TWO_ELLIPSOIDS:    cfg_next.two_ellipsoids    = cfg_data[0];
                esrf_pkg::CFG_THREE_DIMENSIONAL: cfg_next.three_dimensional = cfg_data[0];
                esrf_pkg::CFG_INV_A_SQ:          cfg_next.inv_a_sq          = cfg_data;
                esrf_pkg::CFG_INV_B_SQ:          cfg_next.inv_b_sq          = cfg_data;
                esrf_pkg::CFG_INV_BV_SQ:         cfg_next.inv_bv_sq         = cfg_data;
                esrf_pkg::CFG_INV_C_SQ:          cfg_next.inv_c_sq          = cfg_data;
                esrf_pkg::CFG_STIFFNESS:         cfg_next.stiffness         = cfg_data;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.two_ellipsoids    <= esrf_pkg::RST_TWO_ELLIPSOIDS;
            cfg_reg.three_dimensional <= esrf_pkg::RST_THREE_DIMENSIONAL;
            cfg_reg.inv_a_sq          <= esrf_pkg::RST_INV_SQ;
            cfg_reg.inv_b_sq          <= esrf_pkg::RST_INV_SQ;
            cfg_reg.inv_bv_sq         <= esrf_pkg::RST_INV_SQ;
            cfg_reg.inv_c_sq          <= esrf_pkg::RST_INV_SQ;
            cfg_reg.stiffness         <= esrf_pkg::RST_STIFFNESS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/esrf_energy.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esrf_energy
// Sums the square terms into E, splits it into sign and magnitude and scales
// the magnitude by the stiffness (stages five to eight).
// ----------------------------------------------------------------------------
module esrf_energy (
    input  logic                  clk,
    input  logic [63:0]           term_x,
    input  logic [63:0]           term_y,
    input  logic [63:0]           term_z,
    input  logic                  three_dimensional,
    input  logic [31:0]           stiffness,
    output esrf_pkg::energy_t     energy
);

    logic [63:0]       sum_reg;
    logic [63:0]       sum_next;
    logic [63:0]       emag_reg;
    logic [63:0]       emag_next;
    logic              eneg6_reg;
    logic              eneg6_next;
    logic [63:0]       epl_reg;
    logic [63:0]       epl_next;
    logic [63:0]       eph_reg;
    logic [63:0]       eph_next;
    logic              eneg7_reg;
    esrf_pkg::energy_t energy_reg;
    esrf_pkg::energy_t energy_next;

    always_comb
    begin
        sum_next = term_x + term_y + (three_dimensional ? term_z : 64'd0);

        if (sum_reg >= esrf_pkg::Q24_ONE)
        begin
            emag_next  = sum_reg - esrf_pkg::Q24_ONE;
            eneg6_next = 1'b0;
        end
        else
        begin
            emag_next  = esrf_pkg::Q24_ONE - sum_reg;
            eneg6_next = 1'b1;
        end

        epl_next = emag_reg[31:0] * stiffness;
        eph_next = emag_reg[63:32] * stiffness;

        energy_next.es   = {32'd0, epl_reg} + {eph_reg, 32'd0};
        energy_next.eneg = eneg7_reg;
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        emag_reg   <= emag_next;
        eneg6_reg  <= eneg6_next;
        epl_reg    <= epl_next;
        eph_reg    <= eph_next;
        eneg7_reg  <= eneg6_reg;
        energy_reg <= energy_next;
    end

    assign energy = energy_reg;

endmodule

@@ rtl/core/esrf_axis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esrf_axis
// One coordinate axis: square term into E, gradient, restoring term and the
// saturating add onto the incoming force.
// ----------------------------------------------------------------------------
module esrf_axis (
    input  logic                 clk,
    input  logic signed [31:0]   coord,
    input  logic [31:0]          recip,
    input  logic signed [47:0]   force_in,
    input  esrf_pkg::energy_t    energy,
    output logic [63:0]          term,
    output logic signed [47:0]   force_out,
    output logic                 clamped
);

    localparam int H_DEPTH     = 6;
    localparam int CNEG_DEPTH  = 7;
    localparam int FORCE_DEPTH = 11;
    localparam int NEG_DEPTH   = 4;

    logic [31:0]        cmag;
    logic [63:0]        sq_reg;
    logic [63:0]        sq_next;
    logic [63:0]        h_reg;
    logic [63:0]        h_next;
    logic [31:0]        recip_reg;
    logic [63:0]        pl_reg;
    logic [63:0]        pl_next;
    logic [63:0]        ph_reg;
    logic [63:0]        ph_next;
    logic [63:0]        term_reg;
    logic [63:0]        term_next;
    logic [63:0]        h_pipe_reg [H_DEPTH];
    logic [CNEG_DEPTH-1:0] cneg_pipe_reg;
    logic [47:0]        force_pipe_reg [FORCE_DEPTH];
    logic [NEG_DEPTH-1:0]  neg_pipe_reg;
    logic [63:0]        h8;
    logic [63:0]        p00_reg;
    logic [63:0]        p01_reg;
    logic [63:0]        p10_reg;
    logic [63:0]        p11_reg;
    logic [63:0]        p20_reg;
    logic [63:0]        p21_reg;
    logic [97:0]        a_reg;
    logic [97:0]        a_next;
    logic [96:0]        b_reg;
    logic [96:0]        b_next;
    logic [160:0]       prod_full;
    logic [95:0]        q_reg;
    logic [48:0]        tm_reg;
    logic [48:0]        tm_next;
    logic signed [49:0] delta;
    logic signed [49:0] total;
    logic [47:0]        fin12;
    logic signed [47:0] force_out_reg;
    logic signed [47:0] force_out_next;
    logic               sat_reg;
    logic               sat_next;

    assign cmag = coord[31] ? (~coord + 32'd1) : coord;
    assign h8   = h_pipe_reg[H_DEPTH-1];
    assign fin12 = force_pipe_reg[FORCE_DEPTH-1];

    always_comb
    begin
        sq_next   = cmag * cmag;
        h_next    = cmag * recip;
        pl_next   = sq_reg[31:0] * recip_reg;
        ph_next   = sq_reg[63:32] * recip_reg;
        term_next = ph_reg + {32'd0, pl_reg[63:32]};

        a_next = {34'd0, p00_reg} + {2'd0, p01_reg, 32'd0} + {2'd0, p10_reg, 32'd0};
        b_next = {33'd0, p11_reg} + {33'd0, p20_reg} + {1'b0, p21_reg, 32'd0};

        prod_full = {63'd0, a_reg} + {b_reg, 64'd0};

        if (q_reg > {47'd0, esrf_pkg::TERM_CAP})
        begin
            tm_next = esrf_pkg::TERM_CAP;
        end
        else
        begin
            tm_next = q_reg[48:0];
        end

        delta = neg_pipe_reg[NEG_DEPTH-1] ? -$signed({1'b0, tm_reg}) : $signed({1'b0, tm_reg});
        total = $signed({{2{fin12[47]}}, fin12}) + delta;

        if (total[49:47] == 3'b000 || total[49:47] == 3'b111)
        begin
            force_out_next = total[47:0];
            sat_next       = 1'b0;
        end
        else
        begin
            force_out_next = total[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            sat_next       = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg    <= sq_next;
        h_reg     <= h_next;
        recip_reg <= recip;
        pl_reg    <= pl_next;
        ph_reg    <= ph_next;
        term_reg  <= term_next;

        h_pipe_reg[0] <= h_reg;
        for (int i = 1; i < H_DEPTH; i++)
        begin
            h_pipe_reg[i] <= h_pipe_reg[i-1];
        end

        cneg_pipe_reg <= {cneg_pipe_reg[CNEG_DEPTH-2:0], coord[31]};

        force_pipe_reg[0] <= force_in;
        for (int i = 1; i < FORCE_DEPTH; i++)
        begin
            force_pipe_reg[i] <= force_pipe_reg[i-1];
        end

        p00_reg <= energy.es[31:0]  * h8[31:0];
        p01_reg <= energy.es[31:0]  * h8[63:32];
        p10_reg <= energy.es[63:32] * h8[31:0];
        p11_reg <= energy.es[63:32] * h8[63:32];
        p20_reg <= energy.es[95:64] * h8[31:0];
        p21_reg <= energy.es[95:64] * h8[63:32];
        neg_pipe_reg <= {neg_pipe_reg[NEG_DEPTH-2:0],
                         energy.eneg == cneg_pipe_reg[CNEG_DEPTH-1]};

        a_reg  <= a_next;
        b_reg  <= b_next;
        q_reg  <= prod_full[158:63];
        tm_reg <= tm_next;

        force_out_reg <= force_out_next;
        sat_reg       <= sat_next;
    end

    assign term      = term_reg;
    assign force_out = force_out_reg;
    assign clamped   = sat_reg;

endmodule

@@ rtl/core/ellipsoid_soft_restoring_force.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipsoid_soft_restoring_force
// Adds the soft ellipsoid restoring term -stiffness*E*grad(E) to the force
// on one shell point per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive point_index, pos_*, force_*_in and last_point and raise
//   start; the word is taken at each rising edge with start high and busy
//   low. busy stays low, so a new point may enter in every cycle.
//   Output: done is high for exactly one cycle as a point leaves the last
//   stage, with index_out, force_*_out, saturated and last_out valid in
//   that cycle. Words leave in the order they came, one per cycle at full
//   rate, through the 13-stage pipeline of 32x32 multipliers and wide adds.
//   The receiver cannot stall and takes every word.
//   Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is
//   always high. Write only while no point is in flight.
//   Reset: rst_n clears the valid line and loads the register defaults;
//   points in flight are dropped.
// ----------------------------------------------------------------------------
module ellipsoid_soft_restoring_force (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [15:0]         point_index,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [47:0]  force_x_in,
    input  logic signed [47:0]  force_y_in,
    input  logic signed [47:0]  force_z_in,
    input  logic                last_point,
    output logic                done,
    output logic [15:0]         index_out,
    output logic signed [47:0]  force_x_out,
    output logic signed [47:0]  force_y_out,
    output logic signed [47:0]  force_z_out,
    output logic                saturated,
    output logic                last_out
);

    localparam int LAT = 13;

    esrf_pkg::cfg_t     cfg;
    esrf_pkg::energy_t  energy;

    logic [LAT-1:0]     vld_reg;
    logic [LAT-1:0]     last_reg;
    logic [15:0]        idx_reg [LAT];
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] z_reg;
    logic signed [47:0] fx_reg;
    logic signed [47:0] fy_reg;
    logic signed [47:0] fz_reg;
    logic [31:0]        ry;
    logic [63:0]        term_x;
    logic [63:0]        term_y;
    logic [63:0]        term_z;
    logic               clamp_x;
    logic               clamp_y;
    logic               clamp_z;

    assign busy = 1'b0;

    esrf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= pos_x;
        y_reg    <= pos_y;
        z_reg    <= pos_z;
        fx_reg   <= force_x_in;
        fy_reg   <= force_y_in;
        fz_reg   <= force_z_in;
        last_reg <= {last_reg[LAT-2:0], last_point};
        idx_reg[0] <= point_index;
        for (int i = 1; i < LAT; i++)
        begin
            idx_reg[i] <= idx_reg[i-1];
        end
    end

    // ventral axis for y at or below zero in pair mode
    assign ry = (cfg.two_ellipsoids && (y_reg[31] || y_reg == 32'sd0)) ?
                cfg.inv_bv_sq : cfg.inv_b_sq;

    esrf_axis u_axis_x (
        .clk       (clk),
        .coord     (x_reg),
        .recip     (cfg.inv_a_sq),
        .force_in  (fx_reg),
        .energy    (energy),
        .term      (term_x),
        .force_out (force_x_out),
        .clamped   (clamp_x)
    );

    esrf_axis u_axis_y (
        .clk       (clk),
        .coord     (y_reg),
        .recip     (ry),
        .force_in  (fy_reg),
        .energy    (energy),
        .term      (term_y),
        .force_out (force_y_out),
        .clamped   (clamp_y)
    );

    esrf_axis u_axis_z (
        .clk       (clk),
        .coord     (z_reg),
        .recip     (cfg.inv_c_sq),
        .force_in  (fz_reg),
        .energy    (energy),
        .term      (term_z),
        .force_out (force_z_out),
        .clamped   (clamp_z)
    );

    esrf_energy u_energy (
        .clk               (clk),
        .term_x            (term_x),
        .term_y            (term_y),
        .term_z            (term_z),
        .three_dimensional (cfg.three_dimensional),
        .stiffness         (cfg.stiffness),
        .energy            (energy)
    );

    assign done      = vld_reg[LAT-1];
    assign index_out = idx_reg[LAT-1];
    assign last_out  = last_reg[LAT-1];
    assign saturated = clamp_x | clamp_y | clamp_z;

endmodule
